@@ rtl/erahl_pkg.sv @@
// shared types and constants for the echo range averaging lamp block
`timescale 1ns / 1ps

package erahl_pkg;

    // average and threshold width, centimetres
    localparam int AVG_W = 11;
    localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

    // lamp codes
    localparam int LAMP_W = 2;
    localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd0;
    localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd1;
    localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_ON_BELOW    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_OFF_ABOVE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_OFF_BELOW = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_ON_ABOVE  = 8'd3;

    // threshold reset values
    localparam logic [AVG_W-1:0] RST_RED_ON_BELOW    = 11'd80;
    localparam logic [AVG_W-1:0] RST_RED_OFF_ABOVE   = 11'd140;
    localparam logic [AVG_W-1:0] RST_GREEN_OFF_BELOW = 11'd275;
    localparam logic [AVG_W-1:0] RST_GREEN_ON_ABOVE  = 11'd305;

    typedef struct packed {
        logic [AVG_W-1:0] red_on_below;
        logic [AVG_W-1:0] red_off_above;
        logic [AVG_W-1:0] green_off_below;
        logic [AVG_W-1:0] green_on_above;
    } thresholds_t;

endpackage

@@ rtl/erahl_lamp_next.sv @@
// lamp decision for one batch average: direct set on the first batch, hysteresis after
`timescale 1ns / 1ps

module erahl_lamp_next
    import erahl_pkg::*;
(
    input  logic [AVG_W-1:0]  average,
    input  thresholds_t       thresholds,
    input  logic [LAMP_W-1:0] lamp_cur,
    input  logic              first_done,
    output logic [LAMP_W-1:0] lamp_next
);

    always_comb begin
        lamp_next = LAMP_RED;
        if (!first_done) begin
            if (average < thresholds.red_off_above) begin
                lamp_next = LAMP_RED;
            end else if (average > thresholds.green_on_above) begin
                lamp_next = LAMP_GREEN;
            end else begin
                lamp_next = LAMP_YELLOW;
            end
        end else begin
            case (lamp_cur)
                LAMP_RED: begin
                    lamp_next = (average > thresholds.red_off_above) ? LAMP_YELLOW : LAMP_RED;
                end
                LAMP_YELLOW: begin
                    if (average <= thresholds.red_on_below) begin
                        lamp_next = LAMP_RED;
                    end else if (average > thresholds.green_on_above) begin
                        lamp_next = LAMP_GREEN;
                    end else begin
                        lamp_next = LAMP_YELLOW;
                    end
                end
                LAMP_GREEN: begin
                    lamp_next = (average <= thresholds.green_off_below) ? LAMP_YELLOW
                                                                        : LAMP_GREEN;
                end
                // unused code falls back to red
                default: begin
                    lamp_next = LAMP_RED;
                end
            endcase
        end
    end

endmodule

@@ rtl/echo_range_average_hysteresis_lamp.sv @@
// top level: echo width to distance, batch averaging and three-lamp hysteresis
`timescale 1ns / 1ps

// Usage
//   s_ channel: one echo width in timer ticks per transaction (s_tdata).
//   m_ channel: one transaction per completed batch of SAMPLES_PER_AVERAGE
//   samples, carrying the lamp (0 red, 1 yellow, 2 green) and the truncated
//   batch average in centimetres, saturated to 2047.
//   cfg_ channel: threshold writes, index 0..3; other indexes are dropped.
//   Write thresholds only while no batch is in flight.
// Timing
//   Four register stages: input, distance, batch sum, result. The last sample
//   of a batch goes through all four to reach m_tdata; one sample is taken
//   every cycle while s_tready is high. The distance conversion and the divide
//   by the batch size are reciprocal multiplies, one per stage.
// Reset and stall
//   aresetn clears the running sum, the sample count, the lamp (red) and the
//   first-batch flag, and restores the threshold defaults.
//   While m_tready is low the result holds; samples that do not close a batch
//   still flow, and s_tready drops only once a finished batch cannot advance.

module echo_range_average_hysteresis_lamp
    import erahl_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 10,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [COUNT_WIDTH-1:0] echo_count, upper bits zero
    input  logic [((COUNT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [1:0] lamp, [12:2] average_cm, [15:13] zero
    output logic [15:0]                            m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [AVG_W-1:0]                       cfg_data
);

    // tick to cm: floor(floor(c/2) * 17 / 500), exact reciprocal multiply
    localparam int H_W        = COUNT_WIDTH - 1;
    localparam int X_W        = COUNT_WIDTH + 4;
    localparam int CM_SHIFT   = X_W + 9;
    localparam int CM_W       = X_W - 8;
    localparam int CM_PROD_W  = 2 * X_W + 1;
    localparam logic [63:0] CM_RECIP = ((64'd1 << CM_SHIFT) + 64'd499) / 64'd500;

    // batch sum and divide by the batch size
    localparam int SUM_W      = CM_W + $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int DIV_L      = $clog2(SAMPLES_PER_AVERAGE);
    localparam int AV_SHIFT   = SUM_W + DIV_L;
    localparam int AV_PROD_W  = AV_SHIFT + SUM_W + 1;
    localparam logic [63:0] AV_RECIP =
        ((64'd1 << AV_SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);
    localparam int Q_W        = (SUM_W > AVG_W) ? SUM_W : AVG_W + 1;

    localparam int CNT_W      = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    // configuration
    thresholds_t thr_reg;

    // pipeline registers
    logic                   in_v_reg;
    logic [COUNT_WIDTH-1:0] in_count_reg;
    logic                   cm_v_reg;
    logic [CM_W-1:0]        cm_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   b_v_reg;
    logic [SUM_W-1:0]       b_sum_reg;
    logic                   out_v_reg;
    logic [LAMP_W-1:0]      out_lamp_reg;
    logic [AVG_W-1:0]       out_avg_reg;
    logic [LAMP_W-1:0]      lamp_state_reg;
    logic                   first_done_reg;

    // handshake chain
    logic out_free, b_fire, b_free, cm_done, cm_fire, cm_free, in_fire, in_free;

    assign out_free = !out_v_reg || m_tready;
    assign b_fire   = b_v_reg && out_free;
    assign b_free   = !b_v_reg || out_free;
    assign cm_done  = (cnt_reg == CNT_LAST);
    // only the batch-closing sample needs room in the batch stage
    assign cm_fire  = cm_v_reg && (!cm_done || b_free);
    assign cm_free  = !cm_v_reg || cm_fire;
    assign in_fire  = in_v_reg && cm_free;
    assign in_free  = !in_v_reg || cm_free;

    assign s_tready  = in_free;
    assign cfg_ready = 1'b1;

    // distance conversion
    logic [H_W-1:0]       half_count;
    logic [X_W-1:0]       scaled;
    logic [CM_PROD_W-1:0] cm_prod;
    logic [CM_W-1:0]      cm_next;

    assign half_count = in_count_reg[COUNT_WIDTH-1:1];
    assign scaled     = (X_W'(half_count) << 4) + X_W'(half_count);
    assign cm_prod    = CM_PROD_W'(scaled) * CM_PROD_W'(CM_RECIP[X_W:0]);
    assign cm_next    = cm_prod[CM_SHIFT +: CM_W];

    // accumulate
    logic [SUM_W-1:0] sum_next;
    assign sum_next = sum_reg + SUM_W'(cm_reg);

    // batch average with saturation
    logic [AV_PROD_W-1:0] av_prod;
    logic [Q_W-1:0]       quot;
    logic [AVG_W-1:0]     avg_sat;
    logic [LAMP_W-1:0]    lamp_next;

    assign av_prod = AV_PROD_W'(b_sum_reg) * AV_PROD_W'(AV_RECIP[SUM_W:0]);
    assign quot    = Q_W'(av_prod[AV_SHIFT +: SUM_W]);
    assign avg_sat = (quot > Q_W'(AVG_MAX)) ? AVG_MAX : quot[AVG_W-1:0];

    erahl_lamp_next u_lamp_next (
        .average    (avg_sat),
        .thresholds (thr_reg),
        .lamp_cur   (lamp_state_reg),
        .first_done (first_done_reg),
        .lamp_next  (lamp_next)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.red_on_below    <= RST_RED_ON_BELOW;
            thr_reg.red_off_above   <= RST_RED_OFF_ABOVE;
            thr_reg.green_off_below <= RST_GREEN_OFF_BELOW;
            thr_reg.green_on_above  <= RST_GREEN_ON_ABOVE;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RED_ON_BELOW:    thr_reg.red_on_below    <= cfg_data;
                CFG_RED_OFF_ABOVE:   thr_reg.red_off_above   <= cfg_data;
                CFG_GREEN_OFF_BELOW: thr_reg.green_off_below <= cfg_data;
                CFG_GREEN_ON_ABOVE:  thr_reg.green_on_above  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg       <= 1'b0;
            cm_v_reg       <= 1'b0;
            b_v_reg        <= 1'b0;
            out_v_reg      <= 1'b0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            lamp_state_reg <= LAMP_RED;
            first_done_reg <= 1'b0;
        end else begin
            if (in_free) begin
                in_v_reg <= s_tvalid;
            end
            if (cm_free) begin
                cm_v_reg <= in_v_reg;
            end
            if (b_free) begin
                b_v_reg <= cm_fire && cm_done;
            end
            if (out_free) begin
                out_v_reg <= b_v_reg;
            end
            if (cm_fire) begin
                if (cm_done) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (b_fire) begin
                lamp_state_reg <= lamp_next;
                first_done_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && in_free) begin
            in_count_reg <= s_tdata[COUNT_WIDTH-1:0];
        end
        if (in_fire) begin
            cm_reg <= cm_next;
        end
        if (cm_fire && cm_done) begin
            b_sum_reg <= sum_next;
        end
        if (b_fire) begin
            out_lamp_reg <= lamp_next;
            out_avg_reg  <= avg_sat;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {3'b000, out_avg_reg, out_lamp_reg};

endmodule
